// File: sv/segx_pkg.sv
// ----------------------------------------------------------------------------
// segx_pkg: shared constants for the segment intersection block
// Default geometry widths, divider sizing and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package segx_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;

	// Divider sizing at the default widths
	localparam int DET_W_DEF = 2 * COORD_WIDTH_DEF + 3;
	localparam int REM_W_DEF = 3 * COORD_WIDTH_DEF + 4 + FRAC_BITS_DEF;
	localparam int QUO_W_DEF = COORD_WIDTH_DEF + FRAC_BITS_DEF + 1;

	// Register map
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam int TOL_W   = 8;
	localparam logic [APB_AW-3:0] REG_TOLERANCE = 1'b0;
	localparam logic [TOL_W-1:0]  TOL_RESET     = 8'd1;

endpackage

`default_nettype wire

// File: sv/segx_if.sv
// ----------------------------------------------------------------------------
// segx_if: streaming channels of the segment intersection block
// One channel for segment pairs and one for intersection results.
// ----------------------------------------------------------------------------
`default_nettype none

interface segx_in_if import segx_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] a_start_x;
	logic signed [COORD_WIDTH-1:0] a_start_y;
	logic signed [COORD_WIDTH-1:0] a_end_x;
	logic signed [COORD_WIDTH-1:0] a_end_y;
	logic signed [COORD_WIDTH-1:0] b_start_x;
	logic signed [COORD_WIDTH-1:0] b_start_y;
	logic signed [COORD_WIDTH-1:0] b_end_x;
	logic signed [COORD_WIDTH-1:0] b_end_y;

	modport source (
		output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		       b_start_x, b_start_y, b_end_x, b_end_y,
		input  ready
	);
	modport sink (
		input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
		       b_start_x, b_start_y, b_end_x, b_end_y,
		output ready
	);
endinterface

interface segx_out_if import segx_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
);
	logic                                    valid;
	logic                                    ready;
	logic                                    hit;
	logic                                    parallel;
	logic signed [COORD_WIDTH+FRAC_BITS-1:0] cross_x;
	logic signed [COORD_WIDTH+FRAC_BITS-1:0] cross_y;

	modport source (output valid, hit, parallel, cross_x, cross_y, input ready);
	modport sink   (input valid, hit, parallel, cross_x, cross_y, output ready);
endinterface

`default_nettype wire

// File: sv/segx_div_cell.sv
// ----------------------------------------------------------------------------
// segx_div_cell: one restoring division step
// Resolves one quotient bit and hands remainder, divisor and quotient on.
// ----------------------------------------------------------------------------
`default_nettype none

module segx_div_cell import segx_pkg::*; #(
	parameter int REM_W = REM_W_DEF,
	parameter int DET_W = DET_W_DEF,
	parameter int QUO_W = QUO_W_DEF,
	parameter int SHIFT = 0
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [REM_W-1:0] rem_i,
	input  wire logic [DET_W-1:0] d_i,
	input  wire logic [QUO_W-1:0] q_i,
	output logic      [REM_W-1:0] rem_o,
	output logic      [DET_W-1:0] d_o,
	output logic      [QUO_W-1:0] q_o
);

	logic [REM_W-1:0] dsh;
	logic             ge;

	assign dsh = REM_W'(d_i) << SHIFT;
	assign ge  = rem_i >= dsh;

	// subtract when the shifted divisor fits, shift the result bit in
	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? rem_i - dsh : rem_i;
			d_o   <= d_i;
			q_o   <= {q_i[QUO_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// File: sv/segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_intersection: intersection point of two 2D line segments
// Pipeline from accept to result: eight arithmetic stages, one divider cell
// per quotient bit and two finishing stages. Throughput: one transaction per
// cycle; a stalled output only holds the stages behind it that have no bubble
// to fill.
// Reset: arst_n clears all valid flags and sets tolerance to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection import segx_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	segx_in_if.sink                seg_in,
	segx_out_if.source             seg_out,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int CW   = COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int DW   = CW + 1;          // line coefficients A, B
	localparam int PW   = CW + DW;         // coefficient times coordinate
	localparam int CWD  = PW + 1;          // C
	localparam int DPW  = 2 * DW;          // determinant products
	localparam int DETW = DPW + 1;         // determinant
	localparam int CH   = DW;              // low slice of C
	localparam int CHI  = CWD - CH;        // high slice of C
	localparam int LPW  = DW + CH + 1;
	localparam int HPW  = DW + CHI;
	localparam int MW   = DW + CWD;        // coefficient times C
	localparam int NUMW = MW + 1;          // numerators
	localparam int NSW  = NUMW + F;        // scaled numerator magnitude
	localparam int QB   = CW + F + 1;      // quotient magnitude bits
	localparam int BW   = QB + 1;          // signed point and box bounds
	localparam int OW   = CW + F;          // result coordinate
	localparam int SC   = 8;               // first divider cell
	localparam int FA   = SC + QB;         // sign stage
	localparam int NS   = FA + 2;          // pipeline depth

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	logic [TOL_W-1:0] tol_q;
	logic             reg_sel;

	assign reg_sel = paddr[APB_AW-1:2] == REG_TOLERANCE;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? APB_DW'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Flow control: a stage advances when any stage from it to the output
	// holds a bubble, or when the output transaction is taken.
	// ------------------------------------------------------------------
	logic [NS-1:0] v_q;
	logic [NS-1:0] en;

	for (genvar i = 0; i < NS; i++) begin : g_en
		assign en[i] = seg_out.ready | ~(&v_q[NS-1:i]);
	end

	assign seg_in.ready  = en[0];
	assign seg_out.valid = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= seg_in.valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: line coefficients and box extents
	// ------------------------------------------------------------------
	logic signed [DW-1:0]    a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [CW-1:0]    ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [CW-1:0]    ext_s1 [8];
	logic [TOL_W-1:0]        tol_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a1_s1 <= DW'(seg_in.a_end_y) - DW'(seg_in.a_start_y);
			b1_s1 <= DW'(seg_in.a_start_x) - DW'(seg_in.a_end_x);
			a2_s1 <= DW'(seg_in.b_end_y) - DW'(seg_in.b_start_y);
			b2_s1 <= DW'(seg_in.b_start_x) - DW'(seg_in.b_end_x);
			ax_s1 <= seg_in.a_start_x;
			ay_s1 <= seg_in.a_start_y;
			bx_s1 <= seg_in.b_start_x;
			by_s1 <= seg_in.b_start_y;
			// order: x max, x min, y max, y min for each segment
			ext_s1[0] <= (seg_in.a_start_x > seg_in.a_end_x) ? seg_in.a_start_x : seg_in.a_end_x;
			ext_s1[1] <= (seg_in.a_start_x < seg_in.a_end_x) ? seg_in.a_start_x : seg_in.a_end_x;
			ext_s1[2] <= (seg_in.a_start_y > seg_in.a_end_y) ? seg_in.a_start_y : seg_in.a_end_y;
			ext_s1[3] <= (seg_in.a_start_y < seg_in.a_end_y) ? seg_in.a_start_y : seg_in.a_end_y;
			ext_s1[4] <= (seg_in.b_start_x > seg_in.b_end_x) ? seg_in.b_start_x : seg_in.b_end_x;
			ext_s1[5] <= (seg_in.b_start_x < seg_in.b_end_x) ? seg_in.b_start_x : seg_in.b_end_x;
			ext_s1[6] <= (seg_in.b_start_y > seg_in.b_end_y) ? seg_in.b_start_y : seg_in.b_end_y;
			ext_s1[7] <= (seg_in.b_start_y < seg_in.b_end_y) ? seg_in.b_start_y : seg_in.b_end_y;
			tol_s1 <= tol_q;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: products for C and the determinant; widened boxes
	// Box bounds then ride alongside the datapath up to the sign stage.
	// ------------------------------------------------------------------
	logic signed [PW-1:0]  ma1x_s2, mb1y_s2, ma2x_s2, mb2y_s2;
	logic signed [DPW-1:0] dp1_s2, dp2_s2;
	logic signed [DW-1:0]  a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [BW-1:0]  bnd_q [1:FA][8];
	logic signed [BW-1:0]  tol_ext;

	assign tol_ext = $signed(BW'(tol_s1));

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ma1x_s2 <= PW'(a1_s1) * PW'(ax_s1);
			mb1y_s2 <= PW'(b1_s1) * PW'(ay_s1);
			ma2x_s2 <= PW'(a2_s1) * PW'(bx_s1);
			mb2y_s2 <= PW'(b2_s1) * PW'(by_s1);
			dp1_s2  <= DPW'(a1_s1) * DPW'(b2_s1);
			dp2_s2  <= DPW'(a2_s1) * DPW'(b1_s1);
			a1_s2   <= a1_s1;
			b1_s2   <= b1_s1;
			a2_s2   <= a2_s1;
			b2_s2   <= b2_s1;
			for (int k = 0; k < 8; k += 2) begin
				bnd_q[1][k]   <= (BW'(ext_s1[k]) <<< F) + tol_ext;
				bnd_q[1][k+1] <= (BW'(ext_s1[k+1]) <<< F) - tol_ext;
			end
		end
		for (int i = 2; i <= FA; i++) begin
			if (en[i]) begin
				bnd_q[i] <= bnd_q[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: C for both lines and the determinant
	// ------------------------------------------------------------------
	logic signed [CWD-1:0]  c1_s3, c2_s3;
	logic signed [DETW-1:0] det_s3;
	logic signed [DW-1:0]   a1_s3, b1_s3, a2_s3, b2_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			c1_s3  <= CWD'(ma1x_s2) + CWD'(mb1y_s2);
			c2_s3  <= CWD'(ma2x_s2) + CWD'(mb2y_s2);
			det_s3 <= DETW'(dp1_s2) - DETW'(dp2_s2);
			a1_s3  <= a1_s2;
			b1_s3  <= b1_s2;
			a2_s3  <= a2_s2;
			b2_s3  <= b2_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: coefficient times C, split into low and high partial products
	// ------------------------------------------------------------------
	logic signed [LPW-1:0]  lb2c1_s4, lb1c2_s4, la1c2_s4, la2c1_s4;
	logic signed [HPW-1:0]  hb2c1_s4, hb1c2_s4, ha1c2_s4, ha2c1_s4;
	logic signed [DETW-1:0] det_s4;
	logic signed [LPW-1:0]  c1_lo, c2_lo;
	logic signed [HPW-1:0]  c1_hi, c2_hi;

	assign c1_lo = LPW'($signed({1'b0, c1_s3[CH-1:0]}));
	assign c2_lo = LPW'($signed({1'b0, c2_s3[CH-1:0]}));
	assign c1_hi = HPW'($signed(c1_s3[CWD-1:CH]));
	assign c2_hi = HPW'($signed(c2_s3[CWD-1:CH]));

	always_ff @(posedge clk) begin
		if (en[3]) begin
			lb2c1_s4 <= LPW'(b2_s3) * c1_lo;
			lb1c2_s4 <= LPW'(b1_s3) * c2_lo;
			la1c2_s4 <= LPW'(a1_s3) * c2_lo;
			la2c1_s4 <= LPW'(a2_s3) * c1_lo;
			hb2c1_s4 <= HPW'(b2_s3) * c1_hi;
			hb1c2_s4 <= HPW'(b1_s3) * c2_hi;
			ha1c2_s4 <= HPW'(a1_s3) * c2_hi;
			ha2c1_s4 <= HPW'(a2_s3) * c1_hi;
			det_s4   <= det_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: recombine partial products
	// ------------------------------------------------------------------
	logic signed [MW-1:0]   pb2c1_s5, pb1c2_s5, pa1c2_s5, pa2c1_s5;
	logic signed [DETW-1:0] det_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			pb2c1_s5 <= (MW'(hb2c1_s4) <<< CH) + MW'(lb2c1_s4);
			pb1c2_s5 <= (MW'(hb1c2_s4) <<< CH) + MW'(lb1c2_s4);
			pa1c2_s5 <= (MW'(ha1c2_s4) <<< CH) + MW'(la1c2_s4);
			pa2c1_s5 <= (MW'(ha2c1_s4) <<< CH) + MW'(la2c1_s4);
			det_s5   <= det_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: Cramer numerators
	// ------------------------------------------------------------------
	logic signed [NUMW-1:0] numx_s6, numy_s6;
	logic signed [DETW-1:0] det_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			numx_s6 <= NUMW'(pb2c1_s5) - NUMW'(pb1c2_s5);
			numy_s6 <= NUMW'(pa1c2_s5) - NUMW'(pa2c1_s5);
			det_s6  <= det_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: magnitudes and quotient signs; flag a zero determinant
	// ------------------------------------------------------------------
	logic [NUMW-1:0] nmx_s7, nmy_s7;
	logic [DETW-1:0] dm_s7;
	logic            negx_q [6:FA-1];
	logic            negy_q [6:FA-1];
	logic            par_q  [6:FA];

	// ------------------------------------------------------------------
	// Stage 8: scale the numerators and catch quotients too large for the
	// divider; such a point lies outside any box, and a zero divisor lands
	// here too.
	// ------------------------------------------------------------------
	logic [NSW-1:0] remx_s8, remy_s8;
	logic [DETW-1:0] d_s8;
	logic [NSW:0]   nbx, nby, dbig;
	logic           ov_q [7:FA];

	assign nbx  = (NSW+1)'(nmx_s7) << F;
	assign nby  = (NSW+1)'(nmy_s7) << F;
	assign dbig = (NSW+1)'(dm_s7) << QB;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			nmx_s7    <= numx_s6[NUMW-1] ? NUMW'(-numx_s6) : NUMW'(numx_s6);
			nmy_s7    <= numy_s6[NUMW-1] ? NUMW'(-numy_s6) : NUMW'(numy_s6);
			dm_s7     <= det_s6[DETW-1] ? DETW'(-det_s6) : DETW'(det_s6);
			negx_q[6] <= numx_s6[NUMW-1] ^ det_s6[DETW-1];
			negy_q[6] <= numy_s6[NUMW-1] ^ det_s6[DETW-1];
			par_q[6]  <= det_s6 == '0;
		end
		if (en[7]) begin
			remx_s8  <= NSW'(nmx_s7) << F;
			remy_s8  <= NSW'(nmy_s7) << F;
			d_s8     <= dm_s7;
			ov_q[7]  <= (nbx >= dbig) || (nby >= dbig);
		end
		// hold the side flags in step with the divider cells
		for (int i = 7; i < FA; i++) begin
			if (en[i]) begin
				negx_q[i] <= negx_q[i-1];
				negy_q[i] <= negy_q[i-1];
			end
		end
		for (int i = 7; i <= FA; i++) begin
			if (en[i]) begin
				par_q[i] <= par_q[i-1];
			end
		end
		for (int i = 8; i <= FA; i++) begin
			if (en[i]) begin
				ov_q[i] <= ov_q[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Divider chains: one cell per quotient bit, most significant first
	// ------------------------------------------------------------------
	logic [NSW-1:0]  remx_c [QB+1];
	logic [NSW-1:0]  remy_c [QB+1];
	logic [DETW-1:0] dx_c   [QB+1];
	logic [DETW-1:0] dy_c   [QB+1];
	logic [QB-1:0]   qx_c   [QB+1];
	logic [QB-1:0]   qy_c   [QB+1];

	assign remx_c[0] = remx_s8;
	assign remy_c[0] = remy_s8;
	assign dx_c[0]   = d_s8;
	assign dy_c[0]   = d_s8;
	assign qx_c[0]   = '0;
	assign qy_c[0]   = '0;

	for (genvar k = 0; k < QB; k++) begin : g_cell
		segx_div_cell #(
			.REM_W (NSW),
			.DET_W (DETW),
			.QUO_W (QB),
			.SHIFT (QB - 1 - k)
		) u_cell_x (
			.clk   (clk),
			.en    (en[SC+k]),
			.rem_i (remx_c[k]),
			.d_i   (dx_c[k]),
			.q_i   (qx_c[k]),
			.rem_o (remx_c[k+1]),
			.d_o   (dx_c[k+1]),
			.q_o   (qx_c[k+1])
		);
		segx_div_cell #(
			.REM_W (NSW),
			.DET_W (DETW),
			.QUO_W (QB),
			.SHIFT (QB - 1 - k)
		) u_cell_y (
			.clk   (clk),
			.en    (en[SC+k]),
			.rem_i (remy_c[k]),
			.d_i   (dy_c[k]),
			.q_i   (qy_c[k]),
			.rem_o (remy_c[k+1]),
			.d_o   (dy_c[k+1]),
			.q_o   (qy_c[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Sign stage: apply the quotient signs (truncation toward zero)
	// ------------------------------------------------------------------
	logic signed [BW-1:0] px_q, py_q;
	logic signed [BW-1:0] qxs, qys;

	assign qxs = $signed({1'b0, qx_c[QB]});
	assign qys = $signed({1'b0, qy_c[QB]});

	always_ff @(posedge clk) begin
		if (en[FA]) begin
			px_q <= negx_q[FA-1] ? -qxs : qxs;
			py_q <= negy_q[FA-1] ? -qys : qys;
		end
	end

	// ------------------------------------------------------------------
	// Output stage: box tests, saturation, result register
	// ------------------------------------------------------------------
	logic                 in_a, in_b, hit_d;
	logic signed [OW-1:0] satx, saty;
	logic                 hit_q, par_out_q;
	logic signed [OW-1:0] cx_q, cy_q;

	assign in_a = px_q <= bnd_q[FA][0] && px_q >= bnd_q[FA][1] &&
	              py_q <= bnd_q[FA][2] && py_q >= bnd_q[FA][3];
	assign in_b = px_q <= bnd_q[FA][4] && px_q >= bnd_q[FA][5] &&
	              py_q <= bnd_q[FA][6] && py_q >= bnd_q[FA][7];
	assign hit_d = !ov_q[FA] && in_a && in_b;

	// clamp to the result range when the top bits disagree
	always_comb begin
		satx = px_q[OW-1:0];
		saty = py_q[OW-1:0];
		if (!(&px_q[BW-1:OW-1]) && (|px_q[BW-1:OW-1])) begin
			satx = px_q[BW-1] ? $signed({1'b1, {(OW-1){1'b0}}})
			                  : $signed({1'b0, {(OW-1){1'b1}}});
		end
		if (!(&py_q[BW-1:OW-1]) && (|py_q[BW-1:OW-1])) begin
			saty = py_q[BW-1] ? $signed({1'b1, {(OW-1){1'b0}}})
			                  : $signed({1'b0, {(OW-1){1'b1}}});
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			hit_q     <= hit_d;
			par_out_q <= par_q[FA];
			cx_q      <= hit_d ? satx : '0;
			cy_q      <= hit_d ? saty : '0;
		end
	end

	assign seg_out.hit      = hit_q;
	assign seg_out.parallel = par_out_q;
	assign seg_out.cross_x  = cx_q;
	assign seg_out.cross_y  = cy_q;

`ifndef NO_ASSERTIONS
	// a parallel pair never reports a hit or a point
	a_par_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		seg_out.valid && seg_out.parallel |->
			!seg_out.hit && seg_out.cross_x == '0 && seg_out.cross_y == '0)
		else $error("parallel result carries a hit or a point");

	// a miss carries a zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		seg_out.valid && !seg_out.hit |->
			seg_out.cross_x == '0 && seg_out.cross_y == '0)
		else $error("miss carries a non-zero point");

	// input is only refused when every stage is full and the output is stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!seg_in.ready |-> seg_out.valid && !seg_out.ready && (&v_q))
		else $error("input refused with a bubble in the pipeline");
`endif

endmodule

`default_nettype wire

// File: tb/segx_checker.sv
// ----------------------------------------------------------------------------
// segx_checker: intersection predictor and result comparator
// Watches both channels, predicts each intersection from the accepted pair
// and the tolerance in force, and compares results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module segx_checker import segx_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	segx_in_if              seg_in,
	segx_out_if             seg_out,
	input  wire logic [7:0] tolerance,
	output int              fail_count,
	output int              pending,
	output int              hit_count,
	output int              parallel_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               hit;
		logic               parallel;
		logic signed [23:0] cross_x;
		logic signed [23:0] cross_y;
	} crossing_t;

	crossing_t expected_crossings[$];

	function automatic longint fix_divide(longint num, longint den);
		longint q;
		longint r;
		q = num / den;
		r = num % den;
		return q * 256 + (r * 256) / den;
	endfunction

	function automatic logic signed [23:0] clamp24(longint v);
		if (v > 64'sd8388607) return 24'sh7fffff;
		if (v < -64'sd8388608) return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic bit within_box(longint px, longint py, longint sx, longint sy,
			longint ex, longint ey, longint tol);
		longint hx, lx, hy, ly;
		hx = (sx > ex ? sx : ex) * 256 + tol;
		lx = (sx < ex ? sx : ex) * 256 - tol;
		hy = (sy > ey ? sy : ey) * 256 + tol;
		ly = (sy < ey ? sy : ey) * 256 - tol;
		return px <= hx && px >= lx && py <= hy && py >= ly;
	endfunction

	function automatic crossing_t predict_crossing(longint c[8], longint tol);
		crossing_t r;
		longint a1, b1, c1, a2, b2, c2, det, px, py;
		r = '0;
		a1 = c[3] - c[1];
		b1 = c[0] - c[2];
		c1 = a1 * c[0] + b1 * c[1];
		a2 = c[7] - c[5];
		b2 = c[4] - c[6];
		c2 = a2 * c[4] + b2 * c[5];
		det = a1 * b2 - a2 * b1;
		if (det == 0) begin
			r.parallel = 1'b1;
			return r;
		end
		px = fix_divide(b2 * c1 - b1 * c2, det);
		py = fix_divide(a1 * c2 - a2 * c1, det);
		if (within_box(px, py, c[0], c[1], c[2], c[3], tol) &&
				within_box(px, py, c[4], c[5], c[6], c[7], tol)) begin
			r.hit = 1'b1;
			r.cross_x = clamp24(px);
			r.cross_y = clamp24(py);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint c[8];
		crossing_t e;
		if (!arst_n) begin
			fail_count <= 0;
			hit_count <= 0;
			parallel_count <= 0;
			expected_crossings.delete();
			pending <= 0;
		end else begin
			if (seg_in.valid && seg_in.ready) begin
				c[0] = seg_in.a_start_x; c[1] = seg_in.a_start_y;
				c[2] = seg_in.a_end_x;   c[3] = seg_in.a_end_y;
				c[4] = seg_in.b_start_x; c[5] = seg_in.b_start_y;
				c[6] = seg_in.b_end_x;   c[7] = seg_in.b_end_y;
				expected_crossings.push_back(predict_crossing(c, longint'(tolerance)));
			end
			if (seg_out.valid && seg_out.ready) begin
				if (expected_crossings.size() == 0) begin
					$error("unexpected result");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_crossings.pop_front();
					if (e.hit) hit_count <= hit_count + 1;
					if (e.parallel) parallel_count <= parallel_count + 1;
					if (seg_out.hit !== e.hit || seg_out.parallel !== e.parallel ||
							seg_out.cross_x !== e.cross_x ||
							seg_out.cross_y !== e.cross_y) begin
						fail_count <= fail_count + 1;
						if (seg_out.hit !== e.hit)
							$error("hit: expected %0d got %0d", e.hit, seg_out.hit);
						if (seg_out.parallel !== e.parallel)
							$error("parallel: expected %0d got %0d", e.parallel,
								seg_out.parallel);
						if (seg_out.cross_x !== e.cross_x)
							$error("cross_x: expected %0d got %0d", e.cross_x,
								seg_out.cross_x);
						if (seg_out.cross_y !== e.cross_y)
							$error("cross_y: expected %0d got %0d", e.cross_y,
								seg_out.cross_y);
					end
				end
			end
			pending <= expected_crossings.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_segment_intersection.sv
// ----------------------------------------------------------------------------
// tb_segment_intersection: stimulus and verdict for the segment intersection
// Drives directed and random segment pairs through three idling phases with
// several tolerance settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_intersection;
	import segx_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = COORD_WIDTH_DEF + FRAC_BITS_DEF + 11;
	localparam int CYCLE_LIMIT = 400000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic [7:0]        tolerance_now = TOL_RESET;

	int fail_count, pending, hit_count, parallel_count;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int pairs_sent = 0;

	segx_in_if  seg_in();
	segx_out_if seg_out();

	segment_intersection u_dut (
		.clk(clk), .arst_n(arst_n), .seg_in(seg_in), .seg_out(seg_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	segx_checker u_checker (
		.clk(clk), .arst_n(arst_n), .seg_in(seg_in), .seg_out(seg_out),
		.tolerance(tolerance_now), .fail_count(fail_count), .pending(pending),
		.hit_count(hit_count), .parallel_count(parallel_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		seg_in.valid = 1'b0;
		{seg_in.a_start_x, seg_in.a_start_y, seg_in.a_end_x, seg_in.a_end_y} = '0;
		{seg_in.b_start_x, seg_in.b_start_y, seg_in.b_end_x, seg_in.b_end_y} = '0;
		seg_out.ready = 1'b0;
	end

	// Receiver back-pressure: stall at the percentage of the current phase
	always @(posedge clk) begin
		if (arst_n)
			seg_out.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Register write in a setup and an access phase; the checker follows the new
	// tolerance from the access edge onwards
	task automatic write_tolerance(input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_TOLERANCE, 2'b00};
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tolerance_now <= value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Hand one pair over; hold valid until the transaction completes
	task automatic send_pair(input logic signed [15:0] c[8]);
		while ($urandom_range(99) < send_idle_pct) begin
			seg_in.valid <= 1'b0;
			@(posedge clk);
		end
		seg_in.valid <= 1'b1;
		seg_in.a_start_x <= c[0]; seg_in.a_start_y <= c[1];
		seg_in.a_end_x <= c[2];   seg_in.a_end_y <= c[3];
		seg_in.b_start_x <= c[4]; seg_in.b_start_y <= c[5];
		seg_in.b_end_x <= c[6];   seg_in.b_end_y <= c[7];
		@(posedge clk);
		while (!seg_in.ready) @(posedge clk);
		pairs_sent++;
	endtask

	task automatic drop_valid();
		seg_in.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drain: wait for every outstanding result, then let the pipe settle
	task automatic drain();
		drop_valid();
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic signed [15:0] any_coord();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(40)) - 16'sd20;
			default: return 16'($urandom);
		endcase
	endfunction

	// Crossing pairs half the time: build B through a point on A so hits are common
	task automatic random_pair();
		logic signed [15:0] c[8];
		int k;
		int span;
		for (k = 0; k < 8; k++) c[k] = any_coord();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: begin
				span = (1 << $urandom_range(15)) - 1;
				for (k = 0; k < 8; k++)
					c[k] = 16'($signed($urandom_range(2 * span)) - span);
				// Mirror B around the midpoint of A so they cross near it
				c[6] = 16'(int'(c[0]) + int'(c[2]) - int'(c[4]));
				c[7] = 16'(int'(c[1]) + int'(c[3]) - int'(c[5]));
			end
			5: begin
				c[4] = c[0] + 16'sd3; c[5] = c[1];
				c[6] = c[2] + 16'sd3; c[7] = c[3];
			end
			6: begin
				c[2] = c[0]; c[3] = c[1];
			end
			default: ;
		endcase
		send_pair(c);
	endtask

	task automatic directed_pairs();
		logic signed [15:0] p[8];
		// Plain crossing at the origin
		p = '{-16'sd10, 16'sd0, 16'sd10, 16'sd0, 16'sd0, -16'sd10, 16'sd0, 16'sd10};
		send_pair(p);
		// Fractional crossing point
		p = '{16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd1};
		send_pair(p);
		// Negative fractional crossing, truncated toward zero
		p = '{16'sd0, 16'sd0, -16'sd3, -16'sd1, -16'sd1, 16'sd0, 16'sd0, -16'sd1};
		send_pair(p);
		// Parallel lines
		p = '{16'sd0, 16'sd0, 16'sd5, 16'sd5, 16'sd1, 16'sd0, 16'sd6, 16'sd5};
		send_pair(p);
		// Collinear overlap
		p = '{16'sd0, 16'sd0, 16'sd4, 16'sd4, 16'sd2, 16'sd2, 16'sd6, 16'sd6};
		send_pair(p);
		// Degenerate segment
		p = '{16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd0, 16'sd0, 16'sd9, 16'sd1};
		send_pair(p);
		// Lines cross outside the boxes
		p = '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd5, -16'sd5, 16'sd5, -16'sd1};
		send_pair(p);
		// Touch at an endpoint: on the box edge
		p = '{16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd4, 16'sd0, 16'sd4, 16'sd9};
		send_pair(p);
		// Just beyond the box edges, out of reach even at the widest tolerance
		p = '{16'sd0, 16'sd0, 16'sd255, 16'sd1, 16'sd0, 16'sd1, 16'sd1, 16'sd2};
		send_pair(p);
		// Full-range diagonals
		p = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
		send_pair(p);
		// Extremes on every field, all bits toggled
		p = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
			16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000};
		send_pair(p);
		p = '{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
			16'shffff, 16'sh0000, 16'sh0001, 16'shfffe};
		send_pair(p);
		// Crossings on the coordinate rim, at the largest and smallest x
		p = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh7ffe, 16'sh0000, 16'sh7fff, 16'sh0000};
		send_pair(p);
		p = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
			16'sh8001, 16'sh0000, 16'sh8000, 16'sh0000};
		send_pair(p);
	endtask

	initial begin
		int phase;
		int k;
		logic [7:0] tol_plan[4];
		tol_plan = '{8'd0, 8'd255, 8'd17, 8'd128};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs at the reset tolerance, then at the extremes
		directed_pairs();
		drain();
		write_tolerance(8'd0);
		directed_pairs();
		drain();
		write_tolerance(8'd255);
		directed_pairs();
		drain();

		// Random phases: receiver idles more, then sender idles more, then neither
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 59 : 0;
			recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 30 : 0;
			write_tolerance(tol_plan[phase]);
			for (k = 0; k < 500; k++) begin
				random_pair();
				// Hold off once until the pipe has emptied
				if (phase == 2 && k == 250) begin
					drop_valid();
					while (pending != 0) @(posedge clk);
				end
			end
			drain();
		end

		$display("%0d pairs sent: %0d hits, %0d parallel, tolerances 0..255",
			pairs_sent, hit_count, parallel_count);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
